/* hdl/pcpa_pkg.sv */
`timescale 1ns / 1ps

package pcpa_pkg;

	// Fixed field widths
	localparam int PAGE_W = 10;
	localparam int CPU_IN_W = 3;
	localparam int CNT_W = 11;

	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Saturation point of a list count
	localparam cnt_t COUNT_MAX = {CNT_W{1'b1}};

	// Request kinds
	localparam logic KIND_FREE = 1'b0;
	localparam logic KIND_ALLOC = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_INVALID = 2'd1,
		STATUS_OOM = 2'd2
	} status_t;

endpackage

/* hdl/pcpa_req_if.sv */
`timescale 1ns / 1ps

interface pcpa_req_if;
	logic valid;
	logic ready;
	logic kind;
	logic [pcpa_pkg::CPU_IN_W-1:0] cpu;
	pcpa_pkg::page_t page;

	modport source (output valid, output kind, output cpu, output page, input ready);
	modport sink (input valid, input kind, input cpu, input page, output ready);
endinterface

/* hdl/pcpa_rsp_if.sv */
`timescale 1ns / 1ps

interface pcpa_rsp_if;
	logic valid;
	logic ready;
	pcpa_pkg::status_t status;
	pcpa_pkg::page_t granted_page;
	logic stole;

	modport source (output valid, output status, output granted_page, output stole, input ready);
	modport sink (input valid, input status, input granted_page, input stole, output ready);
endinterface

/* hdl/pcpa_link_ram.sv */
`timescale 1ns / 1ps

// Next-link store: one write port, one read port with registered data
module pcpa_link_ram #(
	parameter int DEPTH = 1024,
	parameter int DW = 10,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [DW-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hdl/per_cpu_page_allocator_with_steal_core.sv */
`timescale 1ns / 1ps

// Channel   | Dir | Payload                          | Transfer
// ----------+-----+----------------------------------+-------------------
// req       | in  | kind, cpu, page                  | valid & ready
// rsp       | out | status, granted_page, stole      | valid & ready
// cfg       | in  | cfg_wdata (lowest_free_page)     | cfg_we
//
// Free: capture, update. Plain alloc: capture, link RAM read, pop on registered
// data. Steal: count scan over NUM_CPUS, donor list walk of ceil(n/2) (one link
// RAM read per step), splice, pop. The link RAM read port sets the walk rate.
// Reset clears counts at once; no clearing pass over the link RAM.
// One item at a time; a result waits in the output register while the next
// request is taken, and a request stalls before update if that slot is full.
module per_cpu_page_allocator_with_steal_core #(
	parameter int NUM_CPUS = 8,
	parameter int NUM_PAGES = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input pcpa_pkg::page_t cfg_wdata,
	pcpa_req_if.sink req,
	pcpa_rsp_if.source rsp
);

	localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam logic [CW-1:0] LAST_CPU = CW'(NUM_CPUS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP_DATA,
		ST_SCAN,
		ST_SCAN_END,
		ST_WALK,
		ST_SPLICE,
		ST_POP_RD
	} state_t;

	// Requesting cpu folded into range by repeated subtract
	function automatic logic [CW-1:0] cpu_wrap(input logic [pcpa_pkg::CPU_IN_W-1:0] v);
		logic [4:0] t;
		t = 5'(v);
		for (int i = 0; i < 8; i++) begin
			if (t >= 5'(NUM_CPUS)) begin
				t = t - 5'(NUM_CPUS);
			end
		end
		return CW'(t);
	endfunction

	state_t state_q;
	pcpa_pkg::page_t lfp_q;
	pcpa_pkg::cnt_t cnt_q [NUM_CPUS];
	pcpa_pkg::page_t head_q [NUM_CPUS];

	logic kind_q;
	logic [CW-1:0] cpu_q;
	pcpa_pkg::page_t page_q;

	logic [CW-1:0] idx_q;
	logic [CW-1:0] donor_q;
	pcpa_pkg::cnt_t best_q;
	pcpa_pkg::cnt_t rem_q;
	pcpa_pkg::page_t first_q;
	pcpa_pkg::page_t last_q;
	logic stole_q;

	logic ov_q;
	pcpa_pkg::status_t status_q;
	pcpa_pkg::page_t granted_q;
	logic stole_out_q;

	logic slot_free;
	logic rsp_load;
	logic [CW-1:0] lix;
	pcpa_pkg::page_t cur_head;
	pcpa_pkg::cnt_t cur_cnt;
	logic bad_page;
	logic [pcpa_pkg::CNT_W:0] best_inc;
	pcpa_pkg::cnt_t take;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	pcpa_pkg::page_t ram_wdata;
	logic [AW-1:0] ram_raddr;
	pcpa_pkg::page_t ram_rdata;

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = ov_q;
	assign rsp.status = status_q;
	assign rsp.granted_page = granted_q;
	assign rsp.stole = stole_out_q;

	assign slot_free = !ov_q || rsp.ready;

	// Single read index into the per-cpu heads and counts
	always_comb begin
		case (state_q)
			ST_SCAN: lix = idx_q;
			ST_SCAN_END, ST_WALK: lix = donor_q;
			default: lix = cpu_q;
		endcase
	end

	assign cur_head = head_q[lix];
	assign cur_cnt = cnt_q[lix];
	assign bad_page = (page_q < lfp_q) || (32'(page_q) >= 32'(NUM_PAGES));

	// ceil(best / 2)
	assign best_inc = {1'b0, best_q} + {{pcpa_pkg::CNT_W{1'b0}}, 1'b1};
	assign take = best_inc[pcpa_pkg::CNT_W:1];

	// Result register loads at the end of each request
	always_comb begin
		case (state_q)
			ST_EXEC: rsp_load = slot_free && (kind_q == pcpa_pkg::KIND_FREE);
			ST_SCAN_END: rsp_load = (best_q == '0);
			ST_POP_DATA: rsp_load = 1'b1;
			default: rsp_load = 1'b0;
		endcase
	end

	// Link RAM port control
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = AW'(page_q);
		ram_wdata = cur_head;
		case (state_q)
			ST_EXEC: ram_we = slot_free && (kind_q == pcpa_pkg::KIND_FREE) && !bad_page;
			ST_SPLICE: begin
				ram_we = 1'b1;
				ram_waddr = AW'(last_q);
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_WALK: ram_raddr = AW'(ram_rdata);
			default: ram_raddr = AW'(cur_head);
		endcase
	end

	pcpa_link_ram #(
		.DEPTH(NUM_PAGES),
		.DW(pcpa_pkg::PAGE_W)
	) u_link_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer, counts, config and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lfp_q <= '0;
			for (int i = 0; i < NUM_CPUS; i++) begin
				cnt_q[i] <= '0;
			end
			idx_q <= '0;
			donor_q <= '0;
			best_q <= '0;
			stole_q <= 1'b0;
			ov_q <= 1'b0;
			status_q <= pcpa_pkg::STATUS_OK;
			granted_q <= '0;
			stole_out_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				lfp_q <= cfg_wdata;
			end
			if (rsp_load) begin
				ov_q <= 1'b1;
			end else if (ov_q && rsp.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (slot_free) begin
						if (kind_q == pcpa_pkg::KIND_FREE) begin
							if (!bad_page && cur_cnt != pcpa_pkg::COUNT_MAX) begin
								cnt_q[cpu_q] <= cur_cnt + 1'b1;
							end
							status_q <= bad_page ? pcpa_pkg::STATUS_INVALID
								: pcpa_pkg::STATUS_OK;
							granted_q <= '0;
							stole_out_q <= 1'b0;
							state_q <= ST_IDLE;
						end else if (cur_cnt != '0) begin
							stole_q <= 1'b0;
							state_q <= ST_POP_DATA;
						end else begin
							idx_q <= '0;
							donor_q <= '0;
							best_q <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// one count compared per cycle, first max wins
					if (cur_cnt > best_q) begin
						best_q <= cur_cnt;
						donor_q <= idx_q;
					end
					if (idx_q == LAST_CPU) begin
						state_q <= ST_SCAN_END;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SCAN_END: begin
					if (best_q == '0) begin
						status_q <= pcpa_pkg::STATUS_OOM;
						granted_q <= '0;
						stole_out_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (rem_q == '0) begin
						cnt_q[donor_q] <= best_q - take;
						state_q <= ST_SPLICE;
					end
				end
				ST_SPLICE: begin
					cnt_q[cpu_q] <= take;
					stole_q <= 1'b1;
					state_q <= ST_POP_RD;
				end
				ST_POP_RD: begin
					state_q <= ST_POP_DATA;
				end
				ST_POP_DATA: begin
					if (cur_cnt != '0) begin
						cnt_q[cpu_q] <= cur_cnt - 1'b1;
					end
					status_q <= pcpa_pkg::STATUS_OK;
					granted_q <= cur_head;
					stole_out_q <= stole_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request capture, list heads and walk registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					kind_q <= req.kind;
					cpu_q <= cpu_wrap(req.cpu);
					page_q <= req.page;
				end
			end
			ST_EXEC: begin
				if (slot_free && kind_q == pcpa_pkg::KIND_FREE && !bad_page) begin
					head_q[cpu_q] <= page_q;
				end
			end
			ST_SCAN_END: begin
				first_q <= cur_head;
				last_q <= cur_head;
				rem_q <= take - 1'b1;
			end
			ST_WALK: begin
				// registered read data is the link of last_q
				if (rem_q == '0) begin
					head_q[donor_q] <= ram_rdata;
				end else begin
					last_q <= ram_rdata;
					rem_q <= rem_q - 1'b1;
				end
			end
			ST_SPLICE: begin
				head_q[cpu_q] <= first_q;
			end
			ST_POP_DATA: begin
				head_q[cpu_q] <= ram_rdata;
			end
			default: begin
			end
		endcase
	end

endmodule

/* hdl/pcpa_checker.sv */
`timescale 1ns / 1ps

module pcpa_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] status,
	input logic [pcpa_pkg::PAGE_W-1:0] granted_page,
	input logic stole
);

	// A result stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	// One request at a time: busy right after a transfer
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == pcpa_pkg::STATUS_OK || status == pcpa_pkg::STATUS_INVALID
			|| status == pcpa_pkg::STATUS_OOM)
		else $error("undefined status code");

	// Failed requests grant nothing
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != pcpa_pkg::STATUS_OK |-> granted_page == '0 && !stole)
		else $error("failed request carries a page");

	a_stole_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stole |-> status == pcpa_pkg::STATUS_OK)
		else $error("steal flagged on a failed request");

endmodule

bind per_cpu_page_allocator_with_steal_core pcpa_checker u_pcpa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(req.valid),
	.in_ready(req.ready),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.status(rsp.status),
	.granted_page(rsp.granted_page),
	.stole(rsp.stole)
);
